>>> design/fqp_pkg.sv
// fqp_pkg: shared types and constants of the arrival store with two serving orders
// used by fqp_cell and fifo_and_max_priority_queue_unit; depends on nothing

package fqp_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int VALUE_W = 16;
    localparam int ID_W    = 32;
    localparam int KIND_W  = 2;
    localparam int STATUS_W = 2;

    // item kinds; the unused code is served like serve best
    localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OLDEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ID_W-1:0] ID_FIRST = 32'd1;
    localparam logic [ID_W-1:0] ID_LAST  = 32'hFFFF_FFFF;

    // per-cell commands from the control logic
    typedef struct packed {
        logic load;   // take the arriving entry
        logic shift;  // take the neighbor's entry (removal at or before this cell)
    } fqp_cell_ctrl_t;

endpackage

>>> design/fqp_cell.sv
// fqp_cell: one storage cell of the arrival-ordered chain, with its suffix best tracker
// depends on fqp_pkg

module fqp_cell
    import fqp_pkg::*;
#(
    parameter int POS_W = 6,
    parameter int INDEX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fqp_cell_ctrl_t     ctrl,
    input  logic [VALUE_W-1:0] new_value,
    input  logic [ID_W-1:0]    new_id,
    // entry and suffix best of the next cell up the chain
    input  logic               nb_valid,
    input  logic [VALUE_W-1:0] nb_value,
    input  logic [ID_W-1:0]    nb_id,
    input  logic               nb_best_valid,
    input  logic [VALUE_W-1:0] nb_best_value,
    input  logic [POS_W-1:0]   nb_best_pos,
    input  logic [ID_W-1:0]    nb_best_id,
    // this cell's entry and suffix best
    output logic               valid,
    output logic [VALUE_W-1:0] value,
    output logic [ID_W-1:0]    id,
    output logic               best_valid,
    output logic [VALUE_W-1:0] best_value,
    output logic [POS_W-1:0]   best_pos,
    output logic [ID_W-1:0]    best_id
);

    logic               valid_reg, valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               best_valid_reg, best_valid_next;
    logic [VALUE_W-1:0] best_value_reg, best_value_next;
    logic [POS_W-1:0]   best_pos_reg, best_pos_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic               own_wins;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        id_next    = id_reg;
        if (ctrl.shift)
        begin
            valid_next = nb_valid;
            value_next = nb_value;
            id_next    = nb_id;
        end
        else if (ctrl.load)
        begin
            valid_next = 1'b1;
            value_next = new_value;
            id_next    = new_id;
        end
    end

    // lower position arrived earlier, so this cell keeps ties
    assign own_wins = valid_reg && (!nb_best_valid || (value_reg >= nb_best_value));

    always_comb
    begin
        if (own_wins)
        begin
            best_valid_next = 1'b1;
            best_value_next = value_reg;
            best_pos_next   = POS_W'(INDEX);
            best_id_next    = id_reg;
        end
        else
        begin
            best_valid_next = nb_best_valid;
            best_value_next = nb_best_value;
            best_pos_next   = nb_best_pos;
            best_id_next    = nb_best_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        id_reg         <= id_next;
        best_value_reg <= best_value_next;
        best_pos_reg   <= best_pos_next;
        best_id_reg    <= best_id_next;
    end

    assign valid      = valid_reg;
    assign value      = value_reg;
    assign id         = id_reg;
    assign best_valid = best_valid_reg;
    assign best_value = best_value_reg;
    assign best_pos   = best_pos_reg;
    assign best_id    = best_id_reg;

endmodule

>>> design/fifo_and_max_priority_queue_unit.sv
// fifo_and_max_priority_queue_unit: top level of the arrival store with oldest and best serving
// depends on fqp_pkg and fqp_cell

// The store is a chain of CAPACITY cells kept in arrival order: cell 0 holds
// the oldest live entry and new arrivals go into the first empty cell. A
// removal shifts every cell above the removed one down by one place, so the
// order never depends on id values and id wrap is harmless. Each cell also
// registers the best entry (highest value, earliest arrival on ties) among
// itself and the cells above it, taken from its neighbor's register, so the
// winner ripples down one cell per clock and cell 0 holds the overall best.
// An arrive or serve-oldest transaction is taken unless the output register is
// busy, and its result (if any) sits in the output register in the next cycle.
// A serve-best transaction is held off until the best chain has settled after
// the last arrive or removal, as tracked by the settle counter, so back-to-back
// serve-best transactions wait for the chain to settle between them. Every
// transaction except a stored arrival yields exactly one result; a new transaction
// is taken only while the output register is free or being emptied in that cycle.

module fifo_and_max_priority_queue_unit
    import fqp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input transactions
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [VALUE_W-1:0]  amount,
    // result transactions
    output logic                result_valid,
    input  logic                result_stall,
    output logic [ID_W-1:0]     served_id,
    output logic [STATUS_W-1:0] status
);

    localparam int POS_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    // chain signals; entry CAPACITY is the empty end of the chain
    logic               c_valid      [CAPACITY+1];
    logic [VALUE_W-1:0] c_value      [CAPACITY+1];
    logic [ID_W-1:0]    c_id         [CAPACITY+1];
    logic               c_best_valid [CAPACITY+1];
    logic [VALUE_W-1:0] c_best_value [CAPACITY+1];
    logic [POS_W-1:0]   c_best_pos   [CAPACITY+1];
    logic [ID_W-1:0]    c_best_id    [CAPACITY+1];

    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [OCC_W-1:0]    settle_reg, settle_next;
    logic                result_valid_reg, result_valid_next;
    logic [ID_W-1:0]     served_id_reg, served_id_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic             out_busy;
    logic             is_arrive;
    logic             is_oldest;
    logic             is_full;
    logic             is_empty;
    logic             accept;
    logic             do_load;
    logic             do_remove;
    logic [POS_W-1:0] rm_pos;

    // decode the offered transaction; codes other than arrive and oldest serve best
    always_comb
    begin
        is_arrive = 1'b0;
        is_oldest = 1'b0;
        case (kind)
            KIND_ARRIVE: is_arrive = 1'b1;
            KIND_OLDEST: is_oldest = 1'b1;
            default:     ;
        endcase
    end

    assign is_full  = (occ_reg == OCC_W'(CAPACITY));
    assign is_empty = (occ_reg == '0);

    // output register holds a result that is stalled this cycle
    assign out_busy   = result_valid_reg && result_stall;
    // serve best waits for the best chain to settle
    assign item_stall = out_busy || (!is_arrive && !is_oldest && (settle_reg != '0));
    assign accept     = item_valid && !item_stall;

    assign do_load   = accept && is_arrive && !is_full;
    assign do_remove = accept && !is_arrive && !is_empty;
    assign rm_pos    = is_oldest ? '0 : c_best_pos[0];

    // end of chain: nothing above the last cell
    assign c_valid[CAPACITY]      = 1'b0;
    assign c_value[CAPACITY]      = '0;
    assign c_id[CAPACITY]         = '0;
    assign c_best_valid[CAPACITY] = 1'b0;
    assign c_best_value[CAPACITY] = '0;
    assign c_best_pos[CAPACITY]   = '0;
    assign c_best_id[CAPACITY]    = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_chain
        fqp_cell_ctrl_t ctrl;

        assign ctrl.load  = do_load && (occ_reg == OCC_W'(i));
        assign ctrl.shift = do_remove && (POS_W'(i) >= rm_pos);

        fqp_cell #(
            .POS_W (POS_W),
            .INDEX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_value     (amount),
            .new_id        (next_id_reg),
            .nb_valid      (c_valid[i+1]),
            .nb_value      (c_value[i+1]),
            .nb_id         (c_id[i+1]),
            .nb_best_valid (c_best_valid[i+1]),
            .nb_best_value (c_best_value[i+1]),
            .nb_best_pos   (c_best_pos[i+1]),
            .nb_best_id    (c_best_id[i+1]),
            .valid         (c_valid[i]),
            .value         (c_value[i]),
            .id            (c_id[i]),
            .best_valid    (c_best_valid[i]),
            .best_value    (c_best_value[i]),
            .best_pos      (c_best_pos[i]),
            .best_id       (c_best_id[i])
        );
    end

    // occupancy, id counter and settle counter
    always_comb
    begin
        occ_next     = occ_reg;
        next_id_next = next_id_reg;
        settle_next  = settle_reg;
        if (settle_reg != '0)
        begin
            settle_next = settle_reg - OCC_W'(1);
        end
        if (do_load)
        begin
            occ_next     = occ_reg + OCC_W'(1);
            next_id_next = (next_id_reg == ID_LAST) ? ID_FIRST : next_id_reg + ID_W'(1);
            settle_next  = OCC_W'(CAPACITY);
        end
        else if (do_remove)
        begin
            occ_next    = occ_reg - OCC_W'(1);
            settle_next = OCC_W'(CAPACITY);
        end
    end

    // result register
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        served_id_next    = served_id_reg;
        status_next       = status_reg;
        if (accept)
        begin
            if (is_arrive)
            begin
                if (is_full)
                begin
                    result_valid_next = 1'b1;
                    served_id_next    = '0;
                    status_next       = ST_FULL;
                end
            end
            else if (is_empty)
            begin
                result_valid_next = 1'b1;
                served_id_next    = '0;
                status_next       = ST_EMPTY;
            end
            else
            begin
                result_valid_next = 1'b1;
                served_id_next    = is_oldest ? c_id[0] : c_best_id[0];
                status_next       = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg          <= '0;
            next_id_reg      <= ID_FIRST;
            settle_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg          <= occ_next;
            next_id_reg      <= next_id_next;
            settle_reg       <= settle_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        served_id_reg <= served_id_next;
        status_reg    <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign served_id    = served_id_reg;
    assign status       = status_reg;

endmodule
